### src/interval_boundary_table_assert.svh
// ----------------------------------------------------------------------------
// Interval boundary table assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_BOUNDARY_TABLE_ASSERT_SVH
`define INTERVAL_BOUNDARY_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset
`define IBT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Condition in one cycle implies a consequence in the next
`define IBT_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
`else
`define IBT_ASSERT(lbl, cond, msg)
`define IBT_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif

`endif

### src/ibt_pkg.sv
// ----------------------------------------------------------------------------
// ibt_pkg
// Shared types, codes and helpers for the interval boundary table.
// ----------------------------------------------------------------------------
package ibt_pkg;

  localparam int DEFAULT_CAPACITY = 256;

  localparam int POS_W    = 31;
  localparam int LABEL_W  = 2;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 8;

  // positions at or above this are never covered by the last segment
  localparam logic [POS_W-1:0] OPEN_END = 31'h7FFF_FFFE;

  // actions
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_SPLIT  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // label classes
  localparam logic [LABEL_W-1:0] LBL_UNKNOWN = 2'd0;
  localparam logic [LABEL_W-1:0] LBL_SILENT  = 2'd1;
  localparam logic [LABEL_W-1:0] LBL_WORD    = 2'd2;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_ORDER    = 3'd1,
    ST_UNCOVER  = 3'd2,
    ST_FULL     = 3'd3,
    ST_EXISTS   = 3'd4
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RUN,
    S_DECIDE,
    S_WRITE
  } state_t;

  // broadcast command to the row of cells
  typedef struct packed {
    logic               load;   // write pos into the addressed cell
    logic               shift;  // cells above the address take their lower neighbor
    logic [LABEL_W-1:0] label;  // label written with a load
  } cell_ctrl_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic               hit;    // some cell at or below holds start <= pos
    logic               open;   // end of the hit segment not yet seen
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   nxt;
    logic [LABEL_W-1:0] label;
  } carry_t;

  // one result item
  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  index;
    logic [POS_W-1:0]    seg_start;
    logic [POS_W-1:0]    seg_end;
    logic [POS_W-1:0]    seg_size;
    logic [LABEL_W-1:0]  label;
  } result_t;

  // segment length, clamped at zero
  function automatic logic [POS_W-1:0] seg_len(input logic [POS_W-1:0] e,
                                               input logic [POS_W-1:0] s);
    logic [POS_W-1:0] d;
    d = e - s;
    return (e >= s) ? d : '0;
  endfunction

endpackage

### src/interval_boundary_table.sv
// ----------------------------------------------------------------------------
// interval_boundary_table
// Sorted table of segment starts with labels: append, find, split, clear.
// ----------------------------------------------------------------------------
// The table is a row of CAPACITY cells, one entry each. Append and clear
// go through EXEC and WRITE. Find and split go through EXEC, RUN, DECIDE
// and WRITE: in RUN the search token moves through the row one cell per
// clock; in DECIDE a split that inserts loads the new boundary and moves
// every entry above the insertion point up by one cell. One item is worked
// on at a time; a new item is taken while the previous result still waits
// in the output register. total_length is written through cfg_wr_en /
// cfg_wr_data only while the block is idle: a rule for the user, not enforced here.
module interval_boundary_table #(
  parameter int CAPACITY = ibt_pkg::DEFAULT_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [ibt_pkg::POS_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [ibt_pkg::POS_W-1:0]    position,
  input  logic [ibt_pkg::LABEL_W-1:0]  label_in,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ibt_pkg::STATUS_W-1:0] status,
  output logic [ibt_pkg::INDEX_W-1:0]  index,
  output logic [ibt_pkg::POS_W-1:0]    seg_start,
  output logic [ibt_pkg::POS_W-1:0]    seg_end,
  output logic [ibt_pkg::POS_W-1:0]    seg_size,
  output logic [ibt_pkg::LABEL_W-1:0]  label_out
);
  import ibt_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] RUN_LAST = IDX_W'(CAPACITY - 1);

  state_t state, state_next;

  logic [POS_W-1:0]   total_length;
  logic [POS_W-1:0]   pos_q;
  action_t            act_q;
  logic [LABEL_W-1:0] lab_q;
  logic [LABEL_W-1:0] lab_c;

  logic [CNT_W-1:0] count_q, count_next;
  logic [POS_W-1:0] last_q, last_next;
  logic [IDX_W-1:0] run_cnt, run_next;
  result_t          res_q, res_next;
  result_t          out_q;
  logic             out_load;
  logic             in_xfer;

  cell_ctrl_t       ctrl;
  logic [CNT_W-1:0] at_sel;

  logic [POS_W-1:0]   start_w [CAPACITY];
  logic [LABEL_W-1:0] label_w [CAPACITY];
  carry_t             carry_w [CAPACITY];
  logic [IDX_W-1:0]   idx_w   [CAPACITY];

  carry_t           fin;
  logic [IDX_W-1:0] fid;
  logic             found;
  logic [POS_W-1:0] f_end;
  logic [CNT_W-1:0] fid_c;
  logic [CNT_W-1:0] ins_c;
  logic [CNT_W+7:0] app_ext, fid_ext, ins_ext;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= '0;
    end else if (cfg_wr_en) begin
      total_length <= cfg_wr_data;
    end
  end

  // input capture
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pos_q <= position;
      act_q <= action_t'(action);
      lab_q <= label_in;
    end
  end

  assign lab_c = (lab_q > LBL_WORD) ? LBL_WORD : lab_q;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [POS_W-1:0]   p_start;
    logic [LABEL_W-1:0] p_label;
    carry_t             c_in;
    logic [IDX_W-1:0]   i_in;

    if (i == 0) begin : g_first
      assign p_start = '0;
      assign p_label = LBL_UNKNOWN;
      assign c_in    = '0;
      assign i_in    = '0;
    end else begin : g_rest
      assign p_start = start_w[i-1];
      assign p_label = label_w[i-1];
      assign c_in    = carry_w[i-1];
      assign i_in    = idx_w[i-1];
    end

    ibt_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .MY    (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .pos        (pos_q),
      .at         (at_sel),
      .count      (count_q),
      .prev_start (p_start),
      .prev_label (p_label),
      .carry_in   (c_in),
      .idx_in     (i_in),
      .start      (start_w[i]),
      .label      (label_w[i]),
      .carry_out  (carry_w[i]),
      .idx_out    (idx_w[i])
    );
  end

  // search outcome at the end of the row
  assign fin   = carry_w[CAPACITY-1];
  assign fid   = idx_w[CAPACITY-1];
  assign found = fin.hit && !(fin.open && (pos_q >= OPEN_END));
  assign f_end = fin.open ? total_length : fin.nxt;
  assign fid_c = CNT_W'(fid);
  assign ins_c = fid_c + CNT_W'(1);

  // low byte of the reported indexes
  assign app_ext = {8'd0, count_q};
  assign fid_ext = {8'd0, fid_c};
  assign ins_ext = {8'd0, ins_c};

  // state register and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count_q <= CNT_W'(1);
      last_q  <= '0;
      run_cnt <= '0;
    end else begin
      state   <= state_next;
      count_q <= count_next;
      last_q  <= last_next;
      run_cnt <= run_next;
    end
    res_q <= res_next;
  end

  // next state, cell commands and result
  always_comb begin
    state_next = state;
    count_next = count_q;
    last_next  = last_q;
    run_next   = run_cnt;
    res_next   = res_q;
    ctrl       = '0;
    at_sel     = count_q;
    out_load   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (act_q)
          ACT_APPEND: begin
            res_next   = '0;
            state_next = S_WRITE;
            if (count_q >= CAP_C) begin
              res_next.status = ST_FULL;
            end else if ((count_q != '0) && (pos_q <= last_q)) begin
              res_next.status = ST_ORDER;
            end else begin
              ctrl.load          = 1'b1;
              ctrl.label         = lab_c;
              at_sel             = count_q;
              count_next         = count_q + CNT_W'(1);
              last_next          = pos_q;
              res_next.status    = ST_OK;
              res_next.index     = app_ext[7:0];
              res_next.seg_start = pos_q;
              res_next.seg_end   = total_length;
              res_next.seg_size  = seg_len(total_length, pos_q);
              res_next.label     = lab_c;
            end
          end
          ACT_FIND, ACT_SPLIT: begin
            run_next   = '0;
            state_next = S_RUN;
          end
          ACT_CLEAR: begin
            count_next = '0;
            res_next   = '0;
            state_next = S_WRITE;
          end
          default: begin
            state_next = S_WRITE;
          end
        endcase
      end

      S_RUN: begin
        run_next = run_cnt + IDX_W'(1);
        if (run_cnt == RUN_LAST) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_next = S_WRITE;
        res_next   = '0;
        if (!found) begin
          res_next.status = ST_UNCOVER;
        end else if ((act_q == ACT_FIND) || (fin.start == pos_q)) begin
          res_next.status    = (act_q == ACT_FIND) ? ST_OK : ST_EXISTS;
          res_next.index     = fid_ext[7:0];
          res_next.seg_start = fin.start;
          res_next.seg_end   = f_end;
          res_next.seg_size  = seg_len(f_end, fin.start);
          res_next.label     = fin.label;
        end else if (count_q >= CAP_C) begin
          res_next.status = ST_FULL;
        end else begin
          // insert an unknown boundary just above the hit segment
          ctrl.load          = 1'b1;
          ctrl.shift         = 1'b1;
          ctrl.label         = LBL_UNKNOWN;
          at_sel             = ins_c;
          count_next         = count_q + CNT_W'(1);
          if (fin.open) begin
            last_next = pos_q;
          end
          res_next.status    = ST_OK;
          res_next.index     = ins_ext[7:0];
          res_next.seg_start = pos_q;
          res_next.seg_end   = f_end;
          res_next.seg_size  = seg_len(f_end, pos_q);
          res_next.label     = LBL_UNKNOWN;
        end
      end

      S_WRITE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign status    = out_q.status;
  assign index     = out_q.index;
  assign seg_start = out_q.seg_start;
  assign seg_end   = out_q.seg_end;
  assign seg_size  = out_q.seg_size;
  assign label_out = out_q.label;

  // checks
`include "interval_boundary_table_assert.svh"
  `IBT_ASSERT(a_count_bound, count_q <= CAP_C, "entry count above capacity")
  `IBT_ASSERT(a_insert_room, !ctrl.shift || (count_q < CAP_C), "insert into full table")
  `IBT_ASSERT(a_run_bound, (state != S_RUN) || (run_cnt <= RUN_LAST), "search ran past row")
  `IBT_ASSERT_NEXT(a_clear_empty, (state == S_EXEC) && (act_q == ACT_CLEAR), count_q == '0, "clear left entries")
  `IBT_ASSERT_NEXT(a_load_valid, out_load, out_valid, "result load lost")

endmodule

### src/ibt_cell.sv
// ----------------------------------------------------------------------------
// ibt_cell
// One table entry: holds a start and label, shifts up on insert, and
// updates the search token passed along the row.
// ----------------------------------------------------------------------------
module ibt_cell #(
  parameter int IDX_W = 8,
  parameter int CNT_W = 9,
  parameter int MY    = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ibt_pkg::cell_ctrl_t         ctrl,
  input  logic [ibt_pkg::POS_W-1:0]   pos,
  input  logic [CNT_W-1:0]            at,
  input  logic [CNT_W-1:0]            count,
  input  logic [ibt_pkg::POS_W-1:0]   prev_start,
  input  logic [ibt_pkg::LABEL_W-1:0] prev_label,
  input  ibt_pkg::carry_t             carry_in,
  input  logic [IDX_W-1:0]            idx_in,
  output logic [ibt_pkg::POS_W-1:0]   start,
  output logic [ibt_pkg::LABEL_W-1:0] label,
  output ibt_pkg::carry_t             carry_out,
  output logic [IDX_W-1:0]            idx_out
);
  import ibt_pkg::*;

  localparam logic [CNT_W-1:0] MY_C = CNT_W'(MY);
  localparam logic [IDX_W-1:0] MY_I = IDX_W'(MY);

  logic   valid;
  logic   le;
  carry_t carry_next;
  logic [IDX_W-1:0] idx_next;

  assign valid = (MY_C < count);
  assign le    = valid && (start <= pos);

  // entry storage: load at the address, shift up above it
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
      label <= LBL_UNKNOWN;
    end else if (ctrl.load && (MY_C == at)) begin
      start <= pos;
      label <= ctrl.label;
    end else if (ctrl.shift && (MY_C > at) && (MY_C <= count)) begin
      start <= prev_start;
      label <= prev_label;
    end
  end

  // search token: last cell with start <= pos claims it, next valid cell closes it
  always_comb begin
    carry_next = carry_in;
    idx_next   = idx_in;
    if (le) begin
      carry_next.hit   = 1'b1;
      carry_next.open  = 1'b1;
      carry_next.start = start;
      carry_next.nxt   = '0;
      carry_next.label = label;
      idx_next         = MY_I;
    end else if (valid && carry_in.open) begin
      carry_next.open = 1'b0;
      carry_next.nxt  = start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.hit  <= 1'b0;
      carry_out.open <= 1'b0;
    end else begin
      carry_out.hit  <= carry_next.hit;
      carry_out.open <= carry_next.open;
    end
    carry_out.start <= carry_next.start;
    carry_out.nxt   <= carry_next.nxt;
    carry_out.label <= carry_next.label;
    idx_out         <= idx_next;
  end

endmodule
